[design/sttk_pkg.sv]
// ----------------------------------------------------------------------------
// sttk_pkg
// Shared types, character codes and token kinds for the shader text tokenizer.
// ----------------------------------------------------------------------------
package sttk_pkg;

  // scan mode of the lexer front
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_NAME   = 2'd2,
    MODE_HALTED = 2'd3
  } mode_t;

  localparam logic [4:0] KIND_NUMBER = 5'd0;
  localparam logic [4:0] KIND_NAME   = 5'd1;
  localparam logic [4:0] KIND_SEMI   = 5'd2;
  localparam logic [4:0] KIND_LPAREN = 5'd3;
  localparam logic [4:0] KIND_RPAREN = 5'd4;
  localparam logic [4:0] KIND_LBRACE = 5'd5;
  localparam logic [4:0] KIND_RBRACE = 5'd6;
  localparam logic [4:0] KIND_ASSIGN = 5'd7;
  localparam logic [4:0] KIND_COMMA  = 5'd8;
  localparam logic [4:0] KIND_PERIOD = 5'd9;
  localparam logic [4:0] KIND_PLUS   = 5'd10;
  localparam logic [4:0] KIND_MINUS  = 5'd11;
  localparam logic [4:0] KIND_STAR   = 5'd12;
  localparam logic [4:0] KIND_SLASH  = 5'd13;
  localparam logic [4:0] KIND_LESS   = 5'd14;
  localparam logic [4:0] KIND_GREATER = 5'd15;
  localparam logic [4:0] KIND_END    = 5'd16;
  localparam logic [4:0] KIND_ERROR  = 5'd17;

  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_FFEED   = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_ASSIGN  = 8'h3D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;

  localparam int TOK_SLOTS   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [7:0]  bad;
  } tok_t;

  // tokens caused by one accepted byte, in delivery order
  typedef struct packed {
    logic [TOK_SLOTS-1:0] valid;
    tok_t [TOK_SLOTS-1:0] slot;
  } rec_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } qstat_t;

  function automatic logic is_punct(input logic [7:0] b);
    logic hit;
    begin
      unique case (b)
        CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_ASSIGN,
        CH_COMMA, CH_DOT, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LESS,
        CH_GREATER: hit = 1'b1;
        default:    hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] b);
    logic [4:0] k;
    begin
      unique case (b)
        CH_SEMI:    k = KIND_SEMI;
        CH_LPAREN:  k = KIND_LPAREN;
        CH_RPAREN:  k = KIND_RPAREN;
        CH_LBRACE:  k = KIND_LBRACE;
        CH_RBRACE:  k = KIND_RBRACE;
        CH_ASSIGN:  k = KIND_ASSIGN;
        CH_COMMA:   k = KIND_COMMA;
        CH_DOT:     k = KIND_PERIOD;
        CH_PLUS:    k = KIND_PLUS;
        CH_MINUS:   k = KIND_MINUS;
        CH_STAR:    k = KIND_STAR;
        CH_SLASH:   k = KIND_SLASH;
        CH_LESS:    k = KIND_LESS;
        CH_GREATER: k = KIND_GREATER;
        default:    k = KIND_ERROR;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] run_kind(input mode_t m);
    return (m == MODE_NUMBER) ? KIND_NUMBER : KIND_NAME;
  endfunction

endpackage

[design/sttk_front.sv]
// ----------------------------------------------------------------------------
// sttk_front
// Byte classifier and scan state; builds the token record for each byte.
// ----------------------------------------------------------------------------
module sttk_front import sttk_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output rec_t       rec,
  output logic       rec_push
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  mode_t                    mode_r, mode_nxt, mode_mid;
  logic [15:0]              run_start_r, run_start_nxt, start_mid;
  logic [15:0]              run_len_r, run_len_nxt, len_mid, len_inc;
  logic [15:0]              line_r, line_nxt, line_mid;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic                     first_line_r, first_line_nxt;

  logic [POSITION_BITS+15:0] pos_ext, pos_inc_ext;
  logic [15:0]               pos16, pos_inc16;

  logic is_dig, is_alp, is_blank, is_nl;
  logic flush0, emit1, err1, flush_eot;

  assign is_dig   = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign is_alp   = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ||
                    ((text_byte >= 8'h41) && (text_byte <= 8'h5A));
  assign is_blank = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                    (text_byte == CH_CR) || (text_byte == CH_VTAB) ||
                    (text_byte == CH_FFEED);
  assign is_nl    = (text_byte == CH_NEWLINE);

  assign pos_inc     = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  assign pos_ext     = {16'd0, pos_r};
  assign pos_inc_ext = {16'd0, pos_inc};
  assign pos16       = pos_ext[15:0];
  assign pos_inc16   = pos_inc_ext[15:0];
  assign len_inc     = (run_len_r == 16'hFFFF) ? run_len_r : run_len_r + 16'd1;

  // effect of the byte before the end marker is considered
  always_comb begin
    mode_mid  = mode_r;
    start_mid = run_start_r;
    len_mid   = run_len_r;
    line_mid  = line_r;
    flush0    = 1'b0;
    emit1     = 1'b0;
    err1      = 1'b0;
    priority if (mode_r == MODE_NUMBER && (is_dig || text_byte == CH_DOT)) begin
      len_mid = len_inc;
    end else if (mode_r == MODE_NAME && (is_alp || is_dig || text_byte == CH_UNDER)) begin
      len_mid = len_inc;
    end else if (mode_r != MODE_HALTED) begin
      flush0   = (mode_r == MODE_NUMBER) || (mode_r == MODE_NAME);
      mode_mid = MODE_IDLE;
      priority if (is_dig || is_alp) begin
        mode_mid  = is_dig ? MODE_NUMBER : MODE_NAME;
        start_mid = pos16;
        len_mid   = 16'd1;
      end else if (is_nl) begin
        line_mid = (line_r == 16'hFFFF) ? line_r : line_r + 16'd1;
      end else if (is_blank) begin
        line_mid = line_r;
      end else if (is_punct(text_byte)) begin
        emit1 = 1'b1;
      end else begin
        emit1    = 1'b1;
        err1     = 1'b1;
        mode_mid = MODE_HALTED;
      end
    end
  end

  assign flush_eot = end_of_text && ((mode_mid == MODE_NUMBER) || (mode_mid == MODE_NAME));

  // next state
  always_comb begin
    mode_nxt       = mode_r;
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    line_nxt       = line_r;
    pos_nxt        = pos_r;
    first_line_nxt = cfg_wr_en ? cfg_wr_data : first_line_r;
    if (accept) begin
      if (end_of_text) begin
        // next text starts fresh
        mode_nxt      = MODE_IDLE;
        run_start_nxt = 16'd0;
        run_len_nxt   = 16'd0;
        pos_nxt       = '0;
        line_nxt      = {15'd0, first_line_nxt};
      end else begin
        mode_nxt      = mode_mid;
        run_start_nxt = start_mid;
        run_len_nxt   = len_mid;
        line_nxt      = line_mid;
        pos_nxt       = pos_inc;
      end
    end else if (cfg_wr_en && pos_r == '0) begin
      line_nxt = {15'd0, cfg_wr_data};
    end
  end

  // token record
  always_comb begin
    rec.valid = {end_of_text, emit1 || flush_eot, flush0};

    rec.slot[0].kind   = run_kind(mode_r);
    rec.slot[0].start  = run_start_r;
    rec.slot[0].length = run_len_r;
    rec.slot[0].line   = line_r;
    rec.slot[0].bad    = 8'd0;

    if (emit1) begin
      rec.slot[1].kind   = err1 ? KIND_ERROR : punct_kind(text_byte);
      rec.slot[1].start  = pos16;
      rec.slot[1].length = 16'd1;
      rec.slot[1].line   = line_r;
      rec.slot[1].bad    = err1 ? text_byte : 8'd0;
    end else begin
      rec.slot[1].kind   = run_kind(mode_mid);
      rec.slot[1].start  = start_mid;
      rec.slot[1].length = len_mid;
      rec.slot[1].line   = line_mid;
      rec.slot[1].bad    = 8'd0;
    end

    rec.slot[2].kind   = KIND_END;
    rec.slot[2].start  = pos_inc16;
    rec.slot[2].length = 16'd0;
    rec.slot[2].line   = line_mid;
    rec.slot[2].bad    = 8'd0;
  end

  assign rec_push = accept && (|rec.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      run_start_r  <= 16'd0;
      run_len_r    <= 16'd0;
      line_r       <= 16'd1;
      pos_r        <= '0;
      first_line_r <= 1'b1;
    end else begin
      mode_r       <= mode_nxt;
      run_start_r  <= run_start_nxt;
      run_len_r    <= run_len_nxt;
      line_r       <= line_nxt;
      pos_r        <= pos_nxt;
      first_line_r <= first_line_nxt;
    end
  end

endmodule

[design/sttk_queue.sv]
// ----------------------------------------------------------------------------
// sttk_queue
// Short record queue between the classifier and the token serializer.
// ----------------------------------------------------------------------------
module sttk_queue import sttk_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  rec_t   push_rec,
  input  logic   pop,
  output rec_t   head_rec,
  output qstat_t qstat
);

  rec_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_push, do_pop;

  assign qstat.full       = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign qstat.head_valid = (count_r != '0);
  assign do_push          = push && !qstat.full;
  assign do_pop           = pop && qstat.head_valid;
  assign head_rec         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[design/sttk_back.sv]
// ----------------------------------------------------------------------------
// sttk_back
// Token serializer: walks each record one token per cycle into the output
// register while out_stall is low.
// ----------------------------------------------------------------------------
module sttk_back import sttk_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  rec_t   head_rec,
  input  qstat_t qstat,
  output logic   pop,
  input  logic   out_stall,
  output logic   out_valid,
  output tok_t   out_tok,
  output logic   out_last
);

  logic [TOK_SLOTS-1:0] sent_r, sent_nxt, pending, pick, remaining;
  logic [1:0]           sel;
  logic                 load;
  logic                 out_valid_r, out_valid_nxt;
  tok_t                 out_tok_r;
  logic                 out_last_r;

  assign pending = head_rec.valid & ~sent_r;

  always_comb begin
    priority if (pending[0]) sel = 2'd0;
    else if (pending[1]) sel = 2'd1;
    else sel = 2'd2;
  end

  assign pick      = TOK_SLOTS'(1) << sel;
  assign remaining = pending & ~pick;
  assign load      = qstat.head_valid && (!out_valid_r || !out_stall);
  assign pop       = load && (remaining == '0);

  always_comb begin
    sent_nxt = sent_r;
    if (load) sent_nxt = pop ? '0 : (sent_r | pick);
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r  <= head_rec.slot[sel];
      out_last_r <= (remaining == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;
  assign out_last  = out_last_r;

endmodule

[design/shader_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// shader_text_tokenizer
// Byte-serial lexer for shader source text, one byte in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Source bytes enter on the in_ channel with in_end_of_text marking the
//   final byte of a text. Tokens leave on the out_ channel as kind, start
//   offset, length, line and offending byte; out_last_of_run flags the last
//   token that a byte caused. Bytes that cause no token (blanks or newlines
//   outside runs, run continuations, bytes after an error) give no output.
//   cfg_wr_en/cfg_wr_data set the line number of the first line; it takes
//   effect on the line counter only before the first byte of a text.
// Timing:
//   A byte is taken every cycle while the four-record queue has room. The
//   first token of a byte passes through the record queue and the output
//   register. The serializer sends one token per cycle while out_stall is
//   low, so a byte that causes two or three tokens holds the output for each
//   in turn; the queue absorbs these bursts and in_stall rises only when full.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and
//   starts a new text at offset 0 with first line number 1.
// While out_stall is high the token on the output holds; bytes keep being
//   accepted until the queue fills.
// ----------------------------------------------------------------------------
module shader_text_tokenizer import sttk_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [15:0] out_line_number,
  output logic [7:0]  out_bad_byte,
  output logic        out_last_of_run
);

  rec_t   push_rec, head_rec;
  qstat_t qstat;
  logic   accept, push, pop;
  tok_t   out_tok;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  sttk_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .text_byte  (in_text_byte),
    .end_of_text(in_end_of_text),
    .rec        (push_rec),
    .rec_push   (push)
  );

  sttk_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .head_rec(head_rec),
    .qstat   (qstat)
  );

  sttk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_rec (head_rec),
    .qstat    (qstat),
    .pop      (pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_tok  (out_tok),
    .out_last (out_last_of_run)
  );

  assign out_token_kind   = out_tok.kind;
  assign out_token_start  = out_tok.start;
  assign out_token_length = out_tok.length;
  assign out_line_number  = out_tok.line;
  assign out_bad_byte     = out_tok.bad;

endmodule

[design/sttk_checker.sv]
// ----------------------------------------------------------------------------
// sttk_checker
// Port-level checks for the shader text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module sttk_checker import sttk_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic        cfg_wr_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_text_byte,
  input logic        in_end_of_text,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_token_kind,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic [15:0] out_line_number,
  input logic [7:0]  out_bad_byte,
  input logic        out_last_of_run
);

  // a stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
      $stable(out_token_start) && $stable(out_token_length) &&
      $stable(out_line_number) && $stable(out_bad_byte) && $stable(out_last_of_run))
    else $error("stalled token changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token out right after reset");

  // end token closes the byte's burst and carries no text
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_END |-> out_token_length == 16'd0 && out_last_of_run)
    else $error("malformed end token");

  a_bad_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_ERROR |-> out_bad_byte == 8'd0)
    else $error("bad byte on a non-error token");

endmodule

bind shader_text_tokenizer sttk_checker u_sttk_checker (.*);
